>>> rtl/lzwd_pkg.sv
// Shared types and constants for the LZ window decompressor.
// No dependencies; imported by the controller, the datapath and the top level.
package lzwd_pkg;

  // History window geometry (fixed by the format)
  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned WIN_AW    = 12;

  // Field widths
  localparam int unsigned SIZE_W = 24;   // output byte count / size
  localparam int unsigned LEN_W  = 9;    // copy length, up to 273
  localparam int unsigned DIST_W = 13;   // distance, up to 4096

  // Length decoding
  localparam logic [LEN_W-1:0] LEN_BASE = 9'd2;   // short form: code + 2
  localparam logic [LEN_W-1:0] LEN_EXT  = 9'd18;  // long form: chunk + 18

  // One token request
  typedef struct packed {
    logic        is_literal;
    logic [7:0]  chunk_byte;
    logic [15:0] link_word;
  } in_req_t;

  // One result request
  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        token_last;
    logic        stream_done;
    logic        bad_reference;
  } out_res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted token
    logic issue;   // launch the next byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;    // output count has reached the configured size
    logic rem_nz;  // bytes of the current token still to launch
    logic b_busy;  // a byte sits in the write stage
    logic hold;    // write stage blocked by a stalled output
  } dp_sts_t;

endpackage

>>> rtl/lzwd_ctrl.sv
// Token sequencer for the LZ window decompressor.
// Depends on lzwd_pkg for the command and status structs.
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        // a token arriving after the end of stream is dropped
        if (accept && !sts_i.done) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.issue = sts_i.rem_nz && !sts_i.hold;
        if (!sts_i.rem_nz && !sts_i.b_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lzwd_datapath.sv
// Datapath of the LZ window decompressor: size register, history window,
// byte launch and write stages, result packer and output register. Uses lzwd_pkg.
module lzwd_datapath import lzwd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  in_req_t           in_req_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_res_t          out_res_o
);

  localparam int unsigned PW  = 8 * BYTES_PER_RESULT;
  localparam int unsigned PCW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

  // Byte source selection
  localparam logic [1:0] SEL_LIT  = 2'd0;
  localparam logic [1:0] SEL_ZERO = 2'd1;
  localparam logic [1:0] SEL_FWD  = 2'd2;
  localparam logic [1:0] SEL_MEM  = 2'd3;

  logic [7:0] win_mem [WIN_DEPTH];

  logic [SIZE_W-1:0] size_q, count_q;
  logic [LEN_W-1:0]  rem_q;
  logic              first_q;
  logic              lit_q, bad_q;
  logic [7:0]        chunk_q;
  logic [DIST_W-1:0] dist_q;
  logic [SIZE_W:0]   srcpos_q;
  logic [7:0]        rdata_q, prev_q;
  logic              b_valid_q, b_last_q;
  logic [1:0]        b_sel_q;
  logic [PW-1:0]     pack_q;
  logic [PCW-1:0]    pcnt_q;
  logic              out_valid_q;
  out_res_t          out_q;

  // Token decode at load
  logic [3:0]        len_code;
  logic [LEN_W-1:0]  len_full, len_ld;
  logic [SIZE_W-1:0] room;
  logic [DIST_W-1:0] dist_ld;
  logic [SIZE_W:0]   srcpos_ld;

  assign len_code  = in_req_i.link_word[15:12];
  assign len_full  = (len_code != 4'd0) ? ({5'd0, len_code} + LEN_BASE)
                                        : ({1'b0, in_req_i.chunk_byte} + LEN_EXT);
  assign room      = size_q - count_q;
  assign len_ld    = in_req_i.is_literal ? LEN_W'(1) :
                     ((SIZE_W'(len_full) > room) ? room[LEN_W-1:0] : len_full);
  assign dist_ld   = {1'b0, in_req_i.link_word[WIN_AW-1:0]} + DIST_W'(1);
  assign srcpos_ld = {1'b0, count_q} - (SIZE_W+1)'(dist_ld);

  // Launch stage source choice
  logic [1:0] sel_a;
  always_comb begin
    if (lit_q) begin
      sel_a = SEL_LIT;
    end else if (srcpos_q[SIZE_W]) begin
      sel_a = SEL_ZERO;          // before the first output byte
    end else if (!first_q && (dist_q == DIST_W'(1))) begin
      sel_a = SEL_FWD;           // source is the byte now being written
    end else begin
      sel_a = SEL_MEM;
    end
  end

  // Write stage byte
  logic [7:0] b_byte;
  always_comb begin
    case (b_sel_q)
      SEL_LIT:  b_byte = chunk_q;
      SEL_ZERO: b_byte = 8'h00;
      SEL_FWD:  b_byte = prev_q;
      SEL_MEM:  b_byte = rdata_q;
      default:  b_byte = rdata_q;
    endcase
  end

  // Packer
  logic [PCW:0]  pcnt_inc;
  logic [PW-1:0] next_pack;
  logic          flush, hold, b_adv, flush_fire;

  assign pcnt_inc   = {1'b0, pcnt_q} + (PCW+1)'(1);
  assign next_pack  = pack_q | (PW'(b_byte) << {pcnt_q, 3'b000});
  assign flush      = (pcnt_inc == (PCW+1)'(BYTES_PER_RESULT)) || b_last_q;
  assign hold       = b_valid_q && flush && out_valid_q && out_stall_i;
  assign b_adv      = b_valid_q && !hold;
  assign flush_fire = b_adv && flush;

  // Window memory: write from the write stage, read for the launch stage
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      win_mem[count_q[WIN_AW-1:0]] <= b_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= win_mem[srcpos_q[WIN_AW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_W'(1);
      count_q     <= '0;
      rem_q       <= '0;
      first_q     <= 1'b0;
      b_valid_q   <= 1'b0;
      pack_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        rem_q   <= len_ld;
        first_q <= 1'b1;
      end else if (cmd_i.issue) begin
        rem_q   <= rem_q - LEN_W'(1);
        first_q <= 1'b0;
      end
      if (cmd_i.issue) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        count_q <= count_q + SIZE_W'(1);
        if (flush) begin
          pack_q <= '0;
          pcnt_q <= '0;
        end else begin
          pack_q <= next_pack;
          pcnt_q <= pcnt_inc[PCW-1:0];
        end
      end
      if (flush_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lit_q    <= in_req_i.is_literal;
      chunk_q  <= in_req_i.chunk_byte;
      dist_q   <= dist_ld;
      srcpos_q <= srcpos_ld;
      bad_q    <= !in_req_i.is_literal && srcpos_ld[SIZE_W];
    end else if (cmd_i.issue) begin
      srcpos_q <= srcpos_q + (SIZE_W+1)'(1);
    end
    if (cmd_i.issue) begin
      b_sel_q  <= sel_a;
      b_last_q <= (rem_q == LEN_W'(1));
    end
    if (b_adv) begin
      prev_q <= b_byte;
    end
    if (flush_fire) begin
      out_q.data_bytes    <= 64'(next_pack);
      out_q.byte_count    <= 4'(pcnt_inc);
      out_q.token_last    <= b_last_q;
      out_q.stream_done   <= b_last_q &&
                             (({1'b0, count_q} + (SIZE_W+1)'(1)) >= {1'b0, size_q});
      out_q.bad_reference <= bad_q;
    end
  end

  assign sts_o.done   = (count_q >= size_q);
  assign sts_o.rem_nz = (rem_q != '0);
  assign sts_o.b_busy = b_valid_q;
  assign sts_o.hold   = hold;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

>>> rtl/lz_window_decompressor_unit.sv
// Top level of the LZ window decompressor (Yay0 token decoder).
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_datapath.
//
// Usage:
//   Tokens enter on in_valid_i / in_stall_o / in_req_i; a request is taken
//   when valid is high and stall is low. Results leave on out_valid_o /
//   out_stall_i / out_res_o, each up to BYTES_PER_RESULT bytes, first byte
//   in bits 7..0. The output size is written on cfg_valid_i / cfg_data_i,
//   always ready; the user must write it only while no token is in flight,
//   which the block itself does not enforce. Each token is loaded, then its
//   bytes are launched one per cycle while the write stage is not held by a
//   stalled output, then the write stage drains and the sequencer returns to
//   idle. A copy is 1 to 273 bytes long, as the size may cut it to one byte.
//   The single read port of the 4096-byte window yields one copied byte per
//   cycle. Tokens after the stream end are taken and give nothing.
//   A stalled receiver freezes the copy only when a new result is ready and
//   the output register is still full; the window needs no clearing.
//   Reset sets the size to 1 and the output count to zero.
module lz_window_decompressor_unit import lzwd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  lzwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window, copy pipeline and packer
  lzwd_datapath #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  // A new token only meets an empty copy pipeline
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!sts.rem_nz && !sts.b_busy))
    else $error("token accepted while a copy is in flight");

  // No byte is launched while the write stage is blocked or nothing remains
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (sts.rem_nz && !sts.hold))
    else $error("byte launched while blocked or idle");

  // Every result carries between one and a full word of bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_res_o.byte_count != 4'd0) &&
                     (out_res_o.byte_count <= 4'(BYTES_PER_RESULT))))
    else $error("result byte count out of range");

  // End of stream is flagged only on the closing result of a token
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.stream_done) |-> out_res_o.token_last)
    else $error("stream end flagged before the last result of a token");

endmodule

>>> verif/lzwd_checker.sv
// Result checker for the LZ window decompressor: watches the token, result and
// size-write channels, predicts each token's results and compares them.
// Depends on lzwd_pkg.
module lzwd_checker import lzwd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_req_t           in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_res_t          out_res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       due_cnt_o
);

  // Shadow of the decoder: history bytes, bytes produced, configured size
  logic [7:0]        hist_win [WIN_DEPTH];
  logic [SIZE_W-1:0] bytes_made;
  logic [SIZE_W-1:0] size_lim;
  out_res_t          due_results [$];
  int unsigned       fails;

  task automatic emit_byte(input logic [7:0] b);
    hist_win[bytes_made[WIN_AW-1:0]] = b;
    bytes_made = bytes_made + SIZE_W'(1);
  endtask

  // Expand one token into its bytes and pack them into result words
  task automatic decode_token(input in_req_t t);
    logic [7:0]        tok [$];
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    logic [SIZE_W-1:0] room;
    logic [WIN_AW-1:0] rd_pos;
    logic [7:0]        b;
    logic              bad;
    out_res_t          r;
    int unsigned       nres;
    int unsigned       base;
    int unsigned       cnt;
    if (bytes_made >= size_lim) return;   // stream over: token dropped
    bad = 1'b0;
    if (t.is_literal) begin
      tok.push_back(t.chunk_byte);
      emit_byte(t.chunk_byte);
    end else begin
      back_dist = {1'b0, t.link_word[11:0]} + 13'd1;
      if (t.link_word[15:12] != 4'd0) begin
        len = {5'd0, t.link_word[15:12]} + LEN_BASE;
      end else begin
        len = {1'b0, t.chunk_byte} + LEN_EXT;
      end
      room = size_lim - bytes_made;
      if ({15'd0, len} > room) len = room[LEN_W-1:0];
      // byte by byte, so an overlapping copy repeats its own output
      for (int unsigned k = 0; k < len; k++) begin
        if ({11'd0, back_dist} > bytes_made) begin
          b = 8'h00;
          bad = 1'b1;
        end else begin
          rd_pos = bytes_made[WIN_AW-1:0] - back_dist[WIN_AW-1:0];
          b = hist_win[rd_pos];
        end
        tok.push_back(b);
        emit_byte(b);
      end
    end
    nres = (tok.size() + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
    for (int unsigned q = 0; q < nres; q++) begin
      base = q * BYTES_PER_RESULT;
      cnt = tok.size() - base;
      if (cnt > BYTES_PER_RESULT) cnt = BYTES_PER_RESULT;
      r = '0;
      for (int unsigned j = 0; j < cnt; j++) r.data_bytes[8*j +: 8] = tok[base + j];
      r.byte_count    = cnt[3:0];
      r.token_last    = (q + 1 == nres);
      r.stream_done   = r.token_last && (bytes_made >= size_lim);
      r.bad_reference = bad;
      due_results.push_back(r);
    end
  endtask

  task automatic check_result(input out_res_t got);
    out_res_t want;
    if (due_results.size() == 0) begin
      $error("result with none due: data_bytes %h byte_count %0d",
             got.data_bytes, got.byte_count);
      fails++;
      return;
    end
    want = due_results.pop_front();
    if (got.data_bytes !== want.data_bytes) begin
      $error("data_bytes: expected %h, got %h", want.data_bytes, got.data_bytes);
      fails++;
    end
    if (got.byte_count !== want.byte_count) begin
      $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
      fails++;
    end
    if (got.token_last !== want.token_last) begin
      $error("token_last: expected %b, got %b", want.token_last, got.token_last);
      fails++;
    end
    if (got.stream_done !== want.stream_done) begin
      $error("stream_done: expected %b, got %b", want.stream_done, got.stream_done);
      fails++;
    end
    if (got.bad_reference !== want.bad_reference) begin
      $error("bad_reference: expected %b, got %b", want.bad_reference, got.bad_reference);
      fails++;
    end
  endtask

  // Sample all three channels at the edge; counts go out a step later
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_made = '0;
      size_lim   = 24'd1;
      due_results.delete();
      fails      = 0;
      fail_cnt_o <= 0;
      due_cnt_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_lim = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result(out_res_i);
      if (in_valid_i && !in_stall_i) decode_token(in_req_i);
      fail_cnt_o <= fails;
      due_cnt_o  <= due_results.size();
    end
  end

endmodule

>>> verif/tb_lz_window_decompressor_unit.sv
// Testbench top for lz_window_decompressor_unit: drives tokens, size writes and
// receiver stalls; lzwd_checker does the checking.
// Depends on lzwd_pkg, lzwd_checker and the decompressor RTL.
module tb_lz_window_decompressor_unit;
  import lzwd_pkg::*;

  localparam int unsigned BPR          = 8;
  localparam int unsigned RAND_ITEMS   = 185;
  localparam int unsigned HOLD_FROM    = 50;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 24'hFFFFFF;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  in_req_t           in_req = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_res_t          out_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;
  int unsigned       fail_cnt;
  int unsigned       due_cnt;
  logic              hold_req = 1'b0;

  // Sender's own view of the stream, used to shape tokens and phases
  logic [SIZE_W-1:0] size_set = 24'd1;
  logic [SIZE_W-1:0] bytes_sent = '0;
  bit                quiet_phase = 1'b0;
  int unsigned       items_sent;
  int unsigned       cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lz_window_decompressor_unit #(
    .BYTES_PER_RESULT(BPR)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  lzwd_checker #(
    .BYTES_PER_RESULT(BPR)
  ) u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_res_i  (out_res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fail_cnt),
    .due_cnt_o  (due_cnt)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_req_t mk_tok(input logic lit, input logic [7:0] chunk,
                                     input logic [15:0] link);
    in_req_t t;
    t.is_literal = lit;
    t.chunk_byte = chunk;
    t.link_word  = link;
    return t;
  endfunction

  // Mostly well-formed tokens: distances inside the history, short overlaps
  // favoured; a few carry any distance and may reach before the start
  function automatic in_req_t rand_token();
    in_req_t     t;
    int unsigned r;
    int unsigned lim;
    int unsigned d;
    t.is_literal = 1'b0;
    t.chunk_byte = 8'($urandom_range(0, 255));
    t.link_word  = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    lim = (bytes_sent < WIN_DEPTH) ? 32'(bytes_sent) : WIN_DEPTH;
    if (r < 35 || lim == 0) begin
      t.is_literal = 1'b1;
      return t;
    end
    if (r >= 93) return t;
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim)
                                    : $urandom_range(1, (lim < 16) ? lim : 16);
    t.link_word[11:0] = 12'(d - 1);
    if ($urandom_range(0, 3) == 0) begin
      t.link_word[15:12] = 4'd0;
      if ($urandom_range(0, 1) != 0) t.chunk_byte = 8'($urandom_range(0, 15));
    end else if (t.link_word[15:12] == 4'd0) begin
      t.link_word[15:12] = 4'($urandom_range(1, 15));
    end
    return t;
  endfunction

  // Offer one request and hold it until taken, then maybe leave a gap
  task automatic send_token(input in_req_t t);
    logic [LEN_W-1:0] len;
    int unsigned      gap;
    in_req   <= t;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (bytes_sent < size_set) begin
      if (t.is_literal) len = 9'd1;
      else if (t.link_word[15:12] != 4'd0) len = {5'd0, t.link_word[15:12]} + LEN_BASE;
      else len = {1'b0, t.chunk_byte} + LEN_EXT;
      bytes_sent += (len > size_set - bytes_sent) ? size_set - bytes_sent : len;
    end
    gap = quiet_phase ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every due result is out and the unit settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_set = v;
    quiet_phase = ($urandom_range(0, 3) == 0);
  endtask

  // Receiver: random stall bursts and free runs, plus one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    bit          hold_done;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left != 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size left at its reset value: a reference before the start, cut to one byte
    send_token(mk_tok(1'b0, 8'h77, 16'h2003));
    send_token(mk_tok(1'b1, 8'h11, 16'h0000));   // after the end: dropped

    // zero and minimum size: everything dropped
    set_size(24'd0);
    send_token(mk_tok(1'b1, 8'h3C, 16'hFFFF));
    set_size(24'd1);
    send_token(mk_tok(1'b0, 8'h00, 16'h0000));

    // byte extremes, partly-before-start copy, far reference, overlap, truncation
    set_size(24'd45);
    send_token(mk_tok(1'b1, 8'h00, 16'h0000));
    send_token(mk_tok(1'b1, 8'hFF, 16'hFFFF));
    send_token(mk_tok(1'b1, 8'hA5, 16'h5A5A));
    send_token(mk_tok(1'b0, 8'h00, 16'h0004));
    send_token(mk_tok(1'b0, 8'h3C, 16'hFFFF));   // chunk byte unused
    send_token(mk_tok(1'b0, 8'hE7, 16'h1001));
    send_token(mk_tok(1'b0, 8'h81, 16'hF000));   // runs past the size
    send_token(mk_tok(1'b1, 8'h11, 16'h0000));

    // longest copies, the last cut short by the size
    set_size(bytes_sent + 24'd1100);
    send_token(mk_tok(1'b1, 8'h5A, 16'hA5A5));
    send_token(mk_tok(1'b0, 8'hFF, 16'h0006));
    send_token(mk_tok(1'b0, 8'hFF, 16'h0020));
    send_token(mk_tok(1'b0, 8'hFF, 16'h0100));
    send_token(mk_tok(1'b0, 8'hFF, 16'h0002));
    send_token(mk_tok(1'b0, 8'hFF, 16'h0000));

    // random phases, each ending with every result delivered
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if (!hold_req && items_sent >= HOLD_FROM) begin
        set_size(bytes_sent + 24'd1500);
        hold_req <= 1'b1;   // receiver holds off while tokens keep coming
      end else if (items_sent >= RAND_ITEMS - 30) begin
        if (size_set != SIZE_MAX) set_size(SIZE_MAX);
      end else if ($urandom_range(0, 3) == 0) begin
        set_size(bytes_sent + SIZE_W'($urandom_range(1, 16)));
      end else begin
        set_size(bytes_sent + SIZE_W'($urandom_range(100, 1500)));
      end
      while (bytes_sent < size_set && items_sent < RAND_ITEMS) begin
        send_token(rand_token());
        items_sent++;
      end
      if (bytes_sent >= size_set && $urandom_range(0, 1) != 0) send_token(rand_token());
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
